### sv/mmspp_pkg.sv
package mmspp_pkg;

    localparam int MOTORS_DEF     = 8;
    localparam int COUNTS_PER_REV = 8192;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int BAND_EDGE      = 2048;

    localparam int ACT_W   = 3;
    localparam int ID_W    = 3;
    localparam int ANG_W   = 13;
    localparam int SPD_W   = 16;
    localparam int TGT_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int DRV_W   = 16;
    localparam int TURN_W  = 32;
    localparam int LIM_W   = 15;
    localparam int STGT_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam int ERR_W  = 18;
    localparam int DIF_W  = ERR_W + 1;
    localparam int PRD_W  = GAIN_W + 1 + ERR_W;
    localparam int PRDD_W = GAIN_W + 1 + DIF_W;
    localparam int SUM_W  = PRDD_W + 2;

    localparam int INT_LIMIT = 1000 * (2 ** GAIN_FRAC_BITS);
    localparam int INT_W     = $clog2(INT_LIMIT + 1) + 1;

    localparam int STEP_HI_ERR  = 10000;
    localparam int STEP_MID_ERR = 1000;
    localparam int STEP_LO_ERR  = 100;
    localparam int STEP_HI      = 2000;
    localparam int STEP_MID     = 1000;
    localparam int STEP_LO      = 200;

    localparam logic [LIM_W-1:0] MAX_SPEED_RST = 15'd8000;
    localparam logic [LIM_W-1:0] MAX_DRIVE_RST = 15'd16384;

    localparam logic [ACT_W-1:0] ACT_FEEDBACK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET_SPEED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET_POS    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_GAINS  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR_TURN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic                     pos_mode;
        logic signed [STGT_W-1:0] speed_tgt;
        logic signed [TGT_W-1:0]  pos_tgt;
        logic signed [INT_W-1:0]  integ;
        logic signed [ERR_W-1:0]  last_err;
        logic [ANG_W-1:0]         last_angle;
        logic [1:0]               band;
        logic [TURN_W-1:0]        turn;
    } t_entry;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [ANG_W-1:0]        angle;
        logic [SPD_W-1:0]        speed_raw;
        logic signed [TGT_W-1:0] target;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
    } t_item;

    typedef struct packed {
        t_entry           ent;
        logic             fb;
        logic [SPD_W-1:0] speed_raw;
    } t_trk;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } t_ld;

endpackage

### sv/mmspp_state_mem.sv
module mmspp_state_mem #(
    parameter int  MOTORS = mmspp_pkg::MOTORS_DEF,
    localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  mmspp_pkg::t_entry   i_wr_data,
    output mmspp_pkg::t_entry   o_rd_data
);

    mmspp_pkg::t_entry r_mem [MOTORS];
    mmspp_pkg::t_entry r_rd_data;
    logic [MOTORS-1:0] r_valid;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### sv/mmspp_track.sv
module mmspp_track (
    input  logic                                i_clk,
    input  mmspp_pkg::t_item                    i_item,
    input  mmspp_pkg::t_entry                   i_ent,
    input  logic [mmspp_pkg::LIM_W-1:0]         i_max_speed,
    input  mmspp_pkg::t_ld                      i_ld,
    output mmspp_pkg::t_trk                     o_s3
);

    localparam int TW = mmspp_pkg::TGT_W;
    localparam logic signed [TW:0] E_HI  = (TW + 1)'(mmspp_pkg::STEP_HI_ERR);
    localparam logic signed [TW:0] E_MID = (TW + 1)'(mmspp_pkg::STEP_MID_ERR);
    localparam logic signed [TW:0] E_LO  = (TW + 1)'(mmspp_pkg::STEP_LO_ERR);
    localparam logic signed [mmspp_pkg::STGT_W-1:0] S_HI  =
        mmspp_pkg::STGT_W'(mmspp_pkg::STEP_HI);
    localparam logic signed [mmspp_pkg::STGT_W-1:0] S_MID =
        mmspp_pkg::STGT_W'(mmspp_pkg::STEP_MID);
    localparam logic signed [mmspp_pkg::STGT_W-1:0] S_LO  =
        mmspp_pkg::STGT_W'(mmspp_pkg::STEP_LO);
    localparam logic [mmspp_pkg::TURN_W-1:0] CPR =
        mmspp_pkg::TURN_W'(mmspp_pkg::COUNTS_PER_REV);
    localparam logic [mmspp_pkg::TURN_W-1:0] HIGH_EDGE =
        mmspp_pkg::TURN_W'(mmspp_pkg::COUNTS_PER_REV - mmspp_pkg::BAND_EDGE);
    localparam logic [mmspp_pkg::TURN_W-1:0] LOW_EDGE =
        mmspp_pkg::TURN_W'(mmspp_pkg::BAND_EDGE);

    mmspp_pkg::t_trk r_s2;
    mmspp_pkg::t_trk r_s3;
    mmspp_pkg::t_trk n_s2;
    mmspp_pkg::t_trk n_s3;

    logic signed [TW-1:0]               spd_lim;
    logic signed [TW-1:0]               spd_clamped;
    logic [mmspp_pkg::TURN_W-1:0]       ang_ext;
    logic [mmspp_pkg::TURN_W-1:0]       last_ext;
    logic [mmspp_pkg::TURN_W-1:0]       turn_new;
    logic                               now_low;
    logic                               now_high;
    logic                               fwd;
    logic                               bwd;
    logic signed [TW:0]                 pos_err;
    logic signed [mmspp_pkg::STGT_W-1:0] step_tgt;

    // stage 1: command update or angle tracking
    always_comb begin
        spd_lim  = $signed({{(TW - mmspp_pkg::LIM_W){1'b0}}, i_max_speed});
        if (i_item.target > spd_lim) begin
            spd_clamped = spd_lim;
        end else if (i_item.target < -spd_lim) begin
            spd_clamped = -spd_lim;
        end else begin
            spd_clamped = i_item.target;
        end

        ang_ext  = mmspp_pkg::TURN_W'(i_item.angle);
        last_ext = mmspp_pkg::TURN_W'(i_ent.last_angle);
        now_low  = ang_ext < LOW_EDGE;
        now_high = ang_ext > HIGH_EDGE;
        fwd      = i_ent.band[1] && now_low;
        bwd      = i_ent.band[0] && now_high;
        turn_new = i_ent.turn + ang_ext - last_ext
                 + (fwd ? CPR : '0) - (bwd ? CPR : '0);

        n_s2           = '0;
        n_s2.ent       = i_ent;
        n_s2.fb        = (i_item.action == mmspp_pkg::ACT_FEEDBACK);
        n_s2.speed_raw = i_item.speed_raw;
        case (i_item.action)
            mmspp_pkg::ACT_SET_SPEED: begin
                n_s2.ent.pos_mode  = 1'b0;
                n_s2.ent.speed_tgt = spd_clamped[mmspp_pkg::STGT_W-1:0];
            end
            mmspp_pkg::ACT_SET_POS: begin
                n_s2.ent.pos_mode = 1'b1;
                n_s2.ent.pos_tgt  = i_item.target;
            end
            mmspp_pkg::ACT_SET_GAINS: begin
                n_s2.ent.gain_p = i_item.gain_p;
                n_s2.ent.gain_i = i_item.gain_i;
                n_s2.ent.gain_d = i_item.gain_d;
            end
            mmspp_pkg::ACT_CLEAR_TURN: begin
                n_s2.ent.turn = '0;
            end
            mmspp_pkg::ACT_FEEDBACK: begin
                n_s2.ent.band       = {now_high, now_low};
                n_s2.ent.last_angle = i_item.angle;
                n_s2.ent.turn       = turn_new;
            end
            default: begin
            end
        endcase
    end

    // stage 2: stepped speed target in position mode
    always_comb begin
        pos_err = (TW + 1)'(r_s2.ent.pos_tgt) - (TW + 1)'($signed(r_s2.ent.turn));
        if (pos_err > E_HI) begin
            step_tgt = S_HI;
        end else if (pos_err < -E_HI) begin
            step_tgt = -S_HI;
        end else if (pos_err > E_MID) begin
            step_tgt = S_MID;
        end else if (pos_err < -E_MID) begin
            step_tgt = -S_MID;
        end else if (pos_err > E_LO) begin
            step_tgt = S_LO;
        end else if (pos_err < -E_LO) begin
            step_tgt = -S_LO;
        end else begin
            step_tgt = '0;
        end

        n_s3 = r_s2;
        if (r_s2.fb && r_s2.ent.pos_mode) begin
            n_s3.ent.speed_tgt = step_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_s2 <= n_s2;
        end
        if (i_ld.s3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

### sv/mmspp_pid.sv
module mmspp_pid (
    input  logic                                i_clk,
    input  mmspp_pkg::t_trk                     i_s3,
    input  mmspp_pkg::t_ld                      i_ld,
    input  logic [mmspp_pkg::LIM_W-1:0]         i_max_drive,
    output mmspp_pkg::t_entry                   o_wr_ent,
    output logic [mmspp_pkg::TURN_W-1:0]        o_turn,
    output logic signed [mmspp_pkg::DRV_W-1:0]  o_drive
);

    localparam int ERR_W  = mmspp_pkg::ERR_W;
    localparam int DIF_W  = mmspp_pkg::DIF_W;
    localparam int PRD_W  = mmspp_pkg::PRD_W;
    localparam int PRDD_W = mmspp_pkg::PRDD_W;
    localparam int SUM_W  = mmspp_pkg::SUM_W;
    localparam int INT_W  = mmspp_pkg::INT_W;
    localparam int FB     = mmspp_pkg::GAIN_FRAC_BITS;
    localparam logic signed [PRDD_W-1:0] ILIM = PRDD_W'(mmspp_pkg::INT_LIMIT);
    localparam logic signed [SUM_W-1:0]  RND  = SUM_W'((2 ** FB) - 1);

    // stage 4 registers
    mmspp_pkg::t_entry         r4_ent;
    logic                      r4_fb;
    logic signed [ERR_W-1:0]   r4_err;
    logic signed [DIF_W-1:0]   r4_diff;
    // stage 5 registers
    mmspp_pkg::t_entry         r5_ent;
    logic                      r5_fb;
    logic signed [PRD_W-1:0]   r5_p;
    logic signed [PRD_W-1:0]   r5_i;
    logic signed [PRDD_W-1:0]  r5_d;
    // stage 6 and 7 registers
    logic signed [INT_W-1:0]   r6_isum;
    logic signed [SUM_W-2:0]   r6_pd;
    logic [mmspp_pkg::TURN_W-1:0] r6_turn;
    logic signed [SUM_W-1:0]   r7_sum;
    logic [mmspp_pkg::TURN_W-1:0] r7_turn;

    mmspp_pkg::t_entry         n4_ent;
    logic signed [ERR_W-1:0]   n4_err;
    logic signed [DIF_W-1:0]   n4_diff;
    logic signed [PRDD_W-1:0]  isum_raw;
    logic signed [INT_W-1:0]   isum;
    logic signed [SUM_W-2:0]   pd;
    logic signed [SUM_W-1:0]   adj;
    logic signed [SUM_W-1:0]   quo;
    logic signed [SUM_W-1:0]   dlim;

    // stage 3: speed error and its change
    always_comb begin
        n4_err  = ERR_W'(i_s3.ent.speed_tgt) - ERR_W'($signed(i_s3.speed_raw));
        n4_diff = DIF_W'(n4_err) - DIF_W'(i_s3.ent.last_err);
        n4_ent  = i_s3.ent;
        if (i_s3.fb) begin
            n4_ent.last_err = n4_err;
        end
    end

    // stage 5: integral clamp, P plus D sum, write-back data
    always_comb begin
        isum_raw = PRDD_W'(r5_ent.integ) + PRDD_W'(r5_i);
        if (isum_raw > ILIM) begin
            isum = INT_W'(ILIM);
        end else if (isum_raw < -ILIM) begin
            isum = INT_W'(-ILIM);
        end else begin
            isum = INT_W'(isum_raw);
        end
        pd       = (SUM_W - 1)'(r5_p) + (SUM_W - 1)'(r5_d);
        o_wr_ent = r5_ent;
        if (r5_fb) begin
            o_wr_ent.integ = isum;
        end
    end

    // stage 7: truncate toward zero, saturate
    always_comb begin
        adj  = r7_sum + (r7_sum[SUM_W-1] ? RND : '0);
        quo  = adj >>> FB;
        dlim = $signed({{(SUM_W - mmspp_pkg::LIM_W){1'b0}}, i_max_drive});
        if (quo > dlim) begin
            o_drive = mmspp_pkg::DRV_W'(dlim);
        end else if (quo < -dlim) begin
            o_drive = mmspp_pkg::DRV_W'(-dlim);
        end else begin
            o_drive = mmspp_pkg::DRV_W'(quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r4_ent  <= n4_ent;
            r4_fb   <= i_s3.fb;
            r4_err  <= n4_err;
            r4_diff <= n4_diff;
        end
        if (i_ld.s5) begin
            r5_ent <= r4_ent;
            r5_fb  <= r4_fb;
            r5_p   <= $signed({1'b0, r4_ent.gain_p}) * r4_err;
            r5_i   <= $signed({1'b0, r4_ent.gain_i}) * r4_err;
            r5_d   <= $signed({1'b0, r4_ent.gain_d}) * r4_diff;
        end
        if (i_ld.s6) begin
            r6_isum <= isum;
            r6_pd   <= pd;
            r6_turn <= r5_ent.turn;
        end
        if (i_ld.s7) begin
            r7_sum  <= SUM_W'(r6_pd) + SUM_W'(r6_isum);
            r7_turn <= r6_turn;
        end
    end

    assign o_turn = r7_turn;

endmodule

### sv/multi_motor_speed_position_pid_top.sv
// Output: o_m_axis_tvalid rises when a feedback item leaves stage 7 into the output register;
// the result is held there until the master side takes it.
// Throughput: one item per cycle while the output side does not stall the pipeline and no item
// in the first five stages names the same motor; an item for a motor that still has an item there
// waits (read-modify-write of the per-motor state memory).
// Reset: synchronous, active low; empties the pipeline, marks all motor state as zero.
module multi_motor_speed_position_pid_top #(
    parameter int  MOTORS = mmspp_pkg::MOTORS_DEF,
    localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mmspp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mmspp_pkg::LIM_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // motor_id[2:0], angle[15:3], speed_raw[31:16], target_value[63:32],
    // gain_p[79:64], gain_i[95:80], gain_d[111:96]
    input  logic [111:0]                      i_s_axis_tdata,
    // action[2:0]
    input  logic [mmspp_pkg::ACT_W-1:0]       i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_motor[2:0], drive[18:3], turn_position[50:19], zero[55:51]
    output logic [55:0]                       o_m_axis_tdata
);

    localparam int NST   = 7;
    localparam int WB_ST = 5;
    localparam int ID_W  = mmspp_pkg::ID_W;

    logic [mmspp_pkg::LIM_W-1:0] r_max_speed;
    logic [mmspp_pkg::LIM_W-1:0] r_max_drive;

    logic [NST:1]          r_vld;
    logic [NST:1]          r_fb;
    logic [ID_W-1:0]       r_mid [1:NST];
    mmspp_pkg::t_item      r_item;

    logic                  r_out_valid;
    logic [ID_W-1:0]       r_out_motor;
    logic [mmspp_pkg::DRV_W-1:0]  r_out_drive;
    logic [mmspp_pkg::TURN_W-1:0] r_out_turn;

    logic [NST:1]          ld;
    mmspp_pkg::t_ld        ld_s;
    logic                  hz;
    logic                  in_ok;
    logic                  acc;
    logic                  acc_ok;
    logic                  wr_en;
    logic                  out_load;
    logic [ID_W-1:0]       in_motor;
    mmspp_pkg::t_item      in_item;
    logic [IDX_W+ID_W-1:0] in_idx_w;
    logic [IDX_W+ID_W-1:0] wb_idx_w;

    mmspp_pkg::t_entry     rd_ent;
    mmspp_pkg::t_entry     wr_ent;
    mmspp_pkg::t_trk       s3;
    logic [mmspp_pkg::TURN_W-1:0] s7_turn;
    logic signed [mmspp_pkg::DRV_W-1:0] s7_drive;

    assign in_motor         = i_s_axis_tdata[2:0];
    assign in_item.action   = i_s_axis_tuser;
    assign in_item.angle    = i_s_axis_tdata[15:3];
    assign in_item.speed_raw = i_s_axis_tdata[31:16];
    assign in_item.target   = $signed(i_s_axis_tdata[63:32]);
    assign in_item.gain_p   = i_s_axis_tdata[79:64];
    assign in_item.gain_i   = i_s_axis_tdata[95:80];
    assign in_item.gain_d   = i_s_axis_tdata[111:96];

    assign in_ok = (i_s_axis_tuser <= mmspp_pkg::ACT_CLEAR_TURN)
                && (32'(in_motor) < 32'(MOTORS));
    assign in_idx_w = (IDX_W + ID_W)'(in_motor);
    assign wb_idx_w = (IDX_W + ID_W)'(r_mid[WB_ST]);

    always_comb begin
        ld[NST] = !r_vld[NST] || !r_fb[NST] || !r_out_valid || i_m_axis_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        hz = 1'b0;
        for (int k = 1; k <= WB_ST; k++) begin
            hz = hz || (r_vld[k] && (r_mid[k] == in_motor));
        end
    end

    assign ld_s.s2 = ld[2];
    assign ld_s.s3 = ld[3];
    assign ld_s.s4 = ld[4];
    assign ld_s.s5 = ld[5];
    assign ld_s.s6 = ld[6];
    assign ld_s.s7 = ld[7];

    assign o_s_axis_tready = ld[1] && !hz;
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_ok   = acc && in_ok;
    assign wr_en    = r_vld[WB_ST] && ld[WB_ST+1];
    assign out_load = r_vld[NST] && r_fb[NST] && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_max_speed <= mmspp_pkg::MAX_SPEED_RST;
            r_max_drive <= mmspp_pkg::MAX_DRIVE_RST;
        end else begin
            if (ld[1]) begin
                r_vld[1] <= acc_ok;
            end
            for (int k = 2; k <= NST; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    mmspp_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_wdata;
                    mmspp_pkg::REG_MAX_DRIVE: r_max_drive <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_item   <= in_item;
            r_mid[1] <= in_motor;
            r_fb[1]  <= (i_s_axis_tuser == mmspp_pkg::ACT_FEEDBACK);
        end
        for (int k = 2; k <= NST; k++) begin
            if (ld[k]) begin
                r_mid[k] <= r_mid[k-1];
                r_fb[k]  <= r_fb[k-1];
            end
        end
        if (out_load) begin
            r_out_motor <= r_mid[NST];
            r_out_drive <= s7_drive;
            r_out_turn  <= s7_turn;
        end
    end

    mmspp_state_mem #(
        .MOTORS    (MOTORS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc_ok),
        .i_rd_addr (in_idx_w[IDX_W-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_addr (wb_idx_w[IDX_W-1:0]),
        .i_wr_data (wr_ent),
        .o_rd_data (rd_ent)
    );

    mmspp_track u_track (
        .i_clk       (i_clk),
        .i_item      (r_item),
        .i_ent       (rd_ent),
        .i_max_speed (r_max_speed),
        .i_ld        (ld_s),
        .o_s3        (s3)
    );

    mmspp_pid u_pid (
        .i_clk       (i_clk),
        .i_s3        (s3),
        .i_ld        (ld_s),
        .i_max_drive (r_max_drive),
        .o_wr_ent    (wr_ent),
        .o_turn      (s7_turn),
        .o_drive     (s7_drive)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_turn, r_out_drive, r_out_motor};

    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_vld[WB_ST]) |-> (r_mid[1] != r_mid[WB_ST]))
        else $error("stage 1 and write-back stage hold the same motor");

    a_drop_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !in_ok) |=> !r_vld[1])
        else $error("ignored item entered the pipeline");

    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_drive) <= $signed({1'b0, r_max_drive})
                      && $signed(r_out_drive) >= -$signed({1'b0, r_max_drive})))
        else $error("drive outside saturation limit");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_MOTORS         = mmspp_pkg::MOTORS_DEF;
    localparam int REV_COUNTS         = 8192;
    localparam int WRAP_BAND          = 2048;
    localparam int FRAC_BITS          = 8;
    localparam longint INTEG_CAP      = 1000 * 256;
    localparam int RESET_CYCLES       = 9;
    localparam int SETTLE_CYCLES      = 20;
    localparam int CYCLE_LIMIT        = 300000;
    localparam int PHASES_PER_PROFILE = 3;
    localparam int ITEMS_PER_PHASE    = 56;
    localparam int LIMIT_MAX          = 32767;

    localparam logic [mmspp_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [mmspp_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [mmspp_pkg::ACT_W-1:0]        action;
        logic [mmspp_pkg::ID_W-1:0]         motor;
        logic [mmspp_pkg::ANG_W-1:0]        angle;
        logic [mmspp_pkg::SPD_W-1:0]        speed_raw;
        logic signed [mmspp_pkg::TGT_W-1:0] target;
        logic [mmspp_pkg::GAIN_W-1:0]       gp;
        logic [mmspp_pkg::GAIN_W-1:0]       gi;
        logic [mmspp_pkg::GAIN_W-1:0]       gd;
    } t_motor_cmd;

    typedef struct {
        logic [mmspp_pkg::ID_W-1:0]          motor;
        logic signed [mmspp_pkg::DRV_W-1:0]  drive;
        logic [mmspp_pkg::TURN_W-1:0]        turn;
    } t_drive_result;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mmspp_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [mmspp_pkg::LIM_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [111:0]                    s_tdata   = '0;
    logic [mmspp_pkg::ACT_W-1:0]     s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [55:0]                     m_tdata;

    int src_idle_pct   = 0;
    int snk_idle_pct   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    int speed_cap;
    int drive_cap;
    logic [mmspp_pkg::GAIN_W-1:0] gain_p_tbl [NUM_MOTORS];
    logic [mmspp_pkg::GAIN_W-1:0] gain_i_tbl [NUM_MOTORS];
    logic [mmspp_pkg::GAIN_W-1:0] gain_d_tbl [NUM_MOTORS];
    bit                           pos_mode   [NUM_MOTORS];
    longint                       speed_goal [NUM_MOTORS];
    longint                       pos_goal   [NUM_MOTORS];
    longint                       integ_acc  [NUM_MOTORS];
    longint                       prev_err   [NUM_MOTORS];
    logic [mmspp_pkg::ANG_W-1:0]  last_ang   [NUM_MOTORS];
    bit                           low_band   [NUM_MOTORS];
    bit                           high_band  [NUM_MOTORS];
    logic [mmspp_pkg::TURN_W-1:0] turn_cnt   [NUM_MOTORS];

    t_drive_result expected_drives [$];

    multi_motor_speed_position_pid_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk) begin : check_drives
        t_drive_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got tdata %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_drives.pop_front();
                if (m_tdata[2:0] !== want.motor) begin
                    $display("%0t: motor mismatch, expected %0d, got %0d",
                             $time, want.motor, m_tdata[2:0]);
                    mismatch_count++;
                end
                if (m_tdata[18:3] !== want.drive) begin
                    $display("%0t: drive mismatch, expected %0d, got %0d",
                             $time, want.drive, $signed(m_tdata[18:3]));
                    mismatch_count++;
                end
                if (m_tdata[50:19] !== want.turn) begin
                    $display("%0t: turn position mismatch, expected %0d, got %0d",
                             $time, $signed(want.turn), $signed(m_tdata[50:19]));
                    mismatch_count++;
                end
            end
        end
    end

    function automatic longint saturate(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint coarse_speed(longint dp);
        if (dp > 10000) return 2000;
        if (dp < -10000) return -2000;
        if (dp > 1000) return 1000;
        if (dp < -1000) return -1000;
        if (dp > 100) return 200;
        if (dp < -100) return -200;
        return 0;
    endfunction

    function automatic void reset_model();
        speed_cap = 8000;
        drive_cap = 16384;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            gain_p_tbl[m] = '0;
            gain_i_tbl[m] = '0;
            gain_d_tbl[m] = '0;
            pos_mode[m]   = 1'b0;
            speed_goal[m] = 0;
            pos_goal[m]   = 0;
            integ_acc[m]  = 0;
            prev_err[m]   = 0;
            last_ang[m]   = '0;
            low_band[m]   = 1'b0;
            high_band[m]  = 1'b0;
            turn_cnt[m]   = '0;
        end
    endfunction

    function automatic void update_motor(t_motor_cmd c);
        int m;
        longint delta, spd, err, acc, drv, pos;
        bit now_low, now_high;
        t_drive_result r;
        m = c.motor;
        case (c.action)
            mmspp_pkg::ACT_SET_SPEED: begin
                pos_mode[m]   = 1'b0;
                speed_goal[m] = saturate(longint'(c.target), longint'(speed_cap));
            end
            mmspp_pkg::ACT_SET_POS: begin
                pos_mode[m] = 1'b1;
                pos_goal[m] = longint'(c.target);
            end
            mmspp_pkg::ACT_SET_GAINS: begin
                gain_p_tbl[m] = c.gp;
                gain_i_tbl[m] = c.gi;
                gain_d_tbl[m] = c.gd;
            end
            mmspp_pkg::ACT_CLEAR_TURN: begin
                turn_cnt[m] = '0;
            end
            mmspp_pkg::ACT_FEEDBACK: begin
                now_low  = (int'(c.angle) < WRAP_BAND);
                now_high = (int'(c.angle) > REV_COUNTS - WRAP_BAND);
                delta = 0;
                if (low_band[m] && now_high) delta -= REV_COUNTS;
                if (high_band[m] && now_low) delta += REV_COUNTS;
                delta += longint'(c.angle) - longint'(last_ang[m]);
                low_band[m]  = now_low;
                high_band[m] = now_high;
                last_ang[m]  = c.angle;
                turn_cnt[m]  = turn_cnt[m] + delta[mmspp_pkg::TURN_W-1:0];
                pos = $signed(turn_cnt[m]);
                if (pos_mode[m]) speed_goal[m] = coarse_speed(pos_goal[m] - pos);
                spd = $signed(c.speed_raw);
                err = speed_goal[m] - spd;
                integ_acc[m] = saturate(integ_acc[m] + longint'(gain_i_tbl[m]) * err,
                                        INTEG_CAP);
                acc = longint'(gain_p_tbl[m]) * err + integ_acc[m]
                    + longint'(gain_d_tbl[m]) * (err - prev_err[m]);
                prev_err[m] = err;
                if (acc < 0) drv = -((-acc) >>> FRAC_BITS);
                else drv = acc >>> FRAC_BITS;
                drv = saturate(drv, longint'(drive_cap));
                r.motor = c.motor;
                r.drive = drv[mmspp_pkg::DRV_W-1:0];
                r.turn  = turn_cnt[m];
                expected_drives.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_motor_cmd blank_cmd(logic [mmspp_pkg::ACT_W-1:0] action, int motor);
        t_motor_cmd c;
        c.action    = action;
        c.motor     = mmspp_pkg::ID_W'(motor);
        c.angle     = mmspp_pkg::ANG_W'($urandom);
        c.speed_raw = mmspp_pkg::SPD_W'($urandom);
        c.target    = $urandom;
        c.gp        = mmspp_pkg::GAIN_W'($urandom);
        c.gi        = mmspp_pkg::GAIN_W'($urandom);
        c.gd        = mmspp_pkg::GAIN_W'($urandom);
        return c;
    endfunction

    function automatic logic [mmspp_pkg::GAIN_W-1:0] random_gain();
        if ($urandom_range(0, 9) < 7) return mmspp_pkg::GAIN_W'($urandom_range(0, 1024));
        return mmspp_pkg::GAIN_W'($urandom);
    endfunction

    function automatic t_motor_cmd random_cmd();
        t_motor_cmd c;
        int roll;
        int m;
        roll = $urandom_range(0, 99);
        m = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                        : $urandom_range(0, NUM_MOTORS - 1);
        if (roll < 60) begin
            c = blank_cmd(mmspp_pkg::ACT_FEEDBACK, m);
            if ($urandom_range(0, 9) >= 4)
                c.angle = last_ang[m]
                        + mmspp_pkg::ANG_W'(int'($urandom_range(0, 3000)) - 1500);
            if ($urandom_range(0, 1) == 0)
                c.speed_raw = mmspp_pkg::SPD_W'(speed_goal[m]
                                                + int'($urandom_range(0, 4000)) - 2000);
        end else if (roll < 70) begin
            c = blank_cmd(mmspp_pkg::ACT_SET_SPEED, m);
            if ($urandom_range(0, 1) == 0)
                c.target = mmspp_pkg::TGT_W'(int'($urandom_range(0, 2 * speed_cap + 1000))
                                             - speed_cap - 500);
        end else if (roll < 78) begin
            c = blank_cmd(mmspp_pkg::ACT_SET_POS, m);
            if ($urandom_range(0, 9) >= 3)
                c.target = mmspp_pkg::TGT_W'(longint'($signed(turn_cnt[m]))
                                             + int'($urandom_range(0, 30000)) - 15000);
        end else if (roll < 88) begin
            c = blank_cmd(mmspp_pkg::ACT_SET_GAINS, m);
            c.gp = random_gain();
            c.gi = random_gain();
            c.gd = random_gain();
        end else if (roll < 94) begin
            c = blank_cmd(mmspp_pkg::ACT_CLEAR_TURN, m);
        end else begin
            c = blank_cmd(mmspp_pkg::ACT_W'($urandom_range(ACT_RESERVED_FIRST,
                                                           ACT_RESERVED_LAST)), m);
        end
        return c;
    endfunction

    task automatic send_cmd(input t_motor_cmd c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.gd, c.gi, c.gp, c.target, c.speed_raw, c.angle, c.motor};
        s_tuser  <= c.action;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        update_motor(c);
    endtask

    task automatic send_feedback(input int motor, input int angle,
                                 input logic [mmspp_pkg::SPD_W-1:0] spd);
        t_motor_cmd c;
        c = blank_cmd(mmspp_pkg::ACT_FEEDBACK, motor);
        c.angle     = mmspp_pkg::ANG_W'(angle);
        c.speed_raw = spd;
        send_cmd(c);
    endtask

    task automatic send_target(input logic [mmspp_pkg::ACT_W-1:0] action, input int motor,
                               input logic signed [mmspp_pkg::TGT_W-1:0] value);
        t_motor_cmd c;
        c = blank_cmd(action, motor);
        c.target = value;
        send_cmd(c);
    endtask

    task automatic send_gains(input int motor, input logic [mmspp_pkg::GAIN_W-1:0] gp,
                              input logic [mmspp_pkg::GAIN_W-1:0] gi,
                              input logic [mmspp_pkg::GAIN_W-1:0] gd);
        t_motor_cmd c;
        c = blank_cmd(mmspp_pkg::ACT_SET_GAINS, motor);
        c.gp = gp;
        c.gi = gi;
        c.gd = gd;
        send_cmd(c);
    endtask

    // drop valid, drain the output side, then hold for commands still in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_drives.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input int speed, input int drive);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= mmspp_pkg::REG_MAX_SPEED;
        cfg_wdata <= mmspp_pkg::LIM_W'(speed);
        @(posedge clk);
        cfg_idx   <= mmspp_pkg::REG_MAX_DRIVE;
        cfg_wdata <= mmspp_pkg::LIM_W'(drive);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        speed_cap = speed;
        drive_cap = drive;
    endtask

    task automatic test_drive_saturation();
        send_gains(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_target(mmspp_pkg::ACT_SET_SPEED, 1, 32'sh7FFF_FFFF);
        send_feedback(1, 8191, 16'h8000);
        send_feedback(1, 0, 16'h7FFF);
        send_target(mmspp_pkg::ACT_SET_SPEED, 1, 32'sh8000_0000);
        send_feedback(1, 4096, 16'h8000);
    endtask

    task automatic test_turn_tracking();
        send_gains(2, 16'h0100, 16'h0020, 16'h0080);
        send_feedback(2, 100, 16'h0000);
        send_feedback(2, 8000, 16'h0010);
        send_feedback(2, 6145, 16'hFFF0);
        send_feedback(2, 2047, 16'h0100);
        send_feedback(2, 2048, 16'hFF00);
        send_target(mmspp_pkg::ACT_CLEAR_TURN, 2, 32'sd0);
        send_feedback(2, 6144, 16'h0000);
    endtask

    task automatic test_position_steps();
        send_target(mmspp_pkg::ACT_SET_POS, 2, 32'sd20001);
        send_feedback(2, 6144, 16'h0000);
        send_target(mmspp_pkg::ACT_SET_POS, 2, 32'sd5097);
        send_feedback(2, 6144, 16'h0000);
        send_target(mmspp_pkg::ACT_SET_POS, 2, 32'sd4196);
        send_feedback(2, 6144, 16'h0000);
        send_target(mmspp_pkg::ACT_SET_POS, 2, 32'sh8000_0000);
        send_feedback(2, 6144, 16'h0000);
    endtask

    task automatic test_ignored_actions();
        send_target(ACT_RESERVED_FIRST, 0, 32'sd1000);
        send_target(ACT_RESERVED_LAST, 0, 32'sd1000);
    endtask

    task automatic test_random_traffic(input int profile);
        int speed_lim;
        int drive_lim;
        case (profile)
            0: begin
                src_idle_pct = 22;
                snk_idle_pct = 57;
            end
            1: begin
                src_idle_pct = 57;
                snk_idle_pct = 22;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
        for (int k = 0; k < PHASES_PER_PROFILE; k++) begin
            settle();
            if (profile == 0 && k == 0) begin
                speed_lim = 0;
                drive_lim = LIMIT_MAX;
            end else if (profile == 0 && k == 1) begin
                speed_lim = LIMIT_MAX;
                drive_lim = 0;
            end else if (profile == 1 && k == 0) begin
                speed_lim = LIMIT_MAX;
                drive_lim = LIMIT_MAX;
            end else if ($urandom_range(0, 1) == 0) begin
                speed_lim = $urandom_range(0, LIMIT_MAX);
                drive_lim = $urandom_range(0, LIMIT_MAX);
            end else begin
                speed_lim = $urandom_range(0, 3000);
                drive_lim = $urandom_range(0, 3000);
            end
            set_limits(speed_lim, drive_lim);
            repeat (ITEMS_PER_PHASE) send_cmd(random_cmd());
        end
    endtask

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_drive_saturation();
        test_turn_tracking();
        test_position_steps();
        test_ignored_actions();
        test_random_traffic(0);
        test_random_traffic(1);
        test_random_traffic(2);
        settle();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
